/* sv/wpc_pkg.sv */
package wpc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int VALUE_BITS = 8;
  localparam int REG_BITS   = 12;
  localparam int IDX_BITS   = 3;
  localparam int CENT_BITS  = 16;
  localparam int LIMIT_LOG  = 24;
  localparam int CNT_BITS   = LIMIT_LOG + 1;

  localparam logic [CNT_BITS-1:0] COUNT_LIMIT = CNT_BITS'(1) << LIMIT_LOG;

  localparam logic [REG_BITS-1:0] WIN_LEFT_RST   = REG_BITS'(0);
  localparam logic [REG_BITS-1:0] WIN_RIGHT_RST  = REG_BITS'(4095);
  localparam logic [REG_BITS-1:0] WIN_TOP_RST    = REG_BITS'(0);
  localparam logic [REG_BITS-1:0] WIN_BOTTOM_RST = REG_BITS'(4095);
  localparam logic [REG_BITS-1:0] EXCL_X_RST     = REG_BITS'(350);
  localparam logic [REG_BITS-1:0] EXCL_Y_RST     = REG_BITS'(1550);

  typedef enum logic [IDX_BITS-1:0] {
    REG_WIN_LEFT   = 3'd0,
    REG_WIN_RIGHT  = 3'd1,
    REG_WIN_TOP    = 3'd2,
    REG_WIN_BOTTOM = 3'd3,
    REG_EXCL_X     = 3'd4,
    REG_EXCL_Y     = 3'd5
  } wpc_reg_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_FINISH
  } wpc_state_t;

  typedef struct packed {
    logic accum;
    logic load;
    logic step;
    logic emit;
  } wpc_cmd_t;

endpackage

/* sv/wpc_pixel_if.sv */
interface wpc_pixel_if #(
  parameter int COORD_BITS = wpc_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [wpc_pkg::VALUE_BITS-1:0]  pixel_value;
  logic [COORD_BITS-1:0]           pos_x;
  logic [COORD_BITS-1:0]           pos_y;
  logic                            frame_last;

  modport source (output valid, pixel_value, pos_x, pos_y, frame_last, input ready);
  modport sink   (input valid, pixel_value, pos_x, pos_y, frame_last, output ready);
endinterface

/* sv/wpc_result_if.sv */
interface wpc_result_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [wpc_pkg::CENT_BITS-1:0]  centroid_x;
  logic [wpc_pkg::CENT_BITS-1:0]  centroid_y;
  logic [wpc_pkg::CNT_BITS-1:0]   pixel_total;

  modport source (output valid, found, centroid_x, centroid_y, pixel_total, input ready);
  modport sink   (input valid, found, centroid_x, centroid_y, pixel_total, output ready);
endinterface

/* sv/wpc_cfg_if.sv */
interface wpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wpc_pkg::IDX_BITS-1:0]  index;
  logic [wpc_pkg::REG_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/wpc_ctrl.sv */
module wpc_ctrl #(
  parameter int DIV_STEPS = wpc_pkg::COORD_BITS_DEF + wpc_pkg::LIMIT_LOG
                            + wpc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output wpc_pkg::wpc_cmd_t cmd
);

  localparam int STEP_BITS = $clog2(DIV_STEPS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_STEPS - 1);

  wpc_pkg::wpc_state_t  state, state_next;
  logic [STEP_BITS-1:0] step_cnt;
  logic                 accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      wpc_pkg::ST_ACCUM: begin
        if (accept && in_last) state_next = wpc_pkg::ST_DIVIDE;
      end
      wpc_pkg::ST_DIVIDE: begin
        if (step_cnt == STEP_LAST) state_next = wpc_pkg::ST_FINISH;
      end
      wpc_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) state_next = wpc_pkg::ST_ACCUM;
      end
      default: state_next = wpc_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      wpc_pkg::ST_ACCUM: begin
        in_ready  = 1'b1;
        cmd.accum = accept;
        cmd.load  = accept && in_last;
      end
      wpc_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      wpc_pkg::ST_FINISH: begin
        cmd.emit = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wpc_pkg::ST_ACCUM;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) step_cnt <= '0;
      else if (cmd.step) step_cnt <= step_cnt + STEP_BITS'(1);
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> step_cnt <= STEP_LAST)
    else $error("divide step counter out of range");

  a_no_take_in_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !in_ready)
    else $error("input taken while dividing");

  a_emit_after_divide: assert property (@(posedge clk) disable iff (rst)
    $fell(cmd.step) |-> state == wpc_pkg::ST_FINISH)
    else $error("divide ended without finish");

endmodule

/* sv/wpc_datapath.sv */
module wpc_datapath #(
  parameter int COORD_BITS = wpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = wpc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wpc_pkg::wpc_cmd_t              cmd,
  input  logic [wpc_pkg::VALUE_BITS-1:0] pixel_value,
  input  logic [COORD_BITS-1:0]          pos_x,
  input  logic [COORD_BITS-1:0]          pos_y,
  wpc_cfg_if.sink                        cfg,
  output logic                           found,
  output logic [wpc_pkg::CENT_BITS-1:0]  centroid_x,
  output logic [wpc_pkg::CENT_BITS-1:0]  centroid_y,
  output logic [wpc_pkg::CNT_BITS-1:0]   pixel_total
);

  localparam int CNT_BITS  = wpc_pkg::CNT_BITS;
  localparam int REG_BITS  = wpc_pkg::REG_BITS;
  localparam int CENT_BITS = wpc_pkg::CENT_BITS;
  localparam int SUM_BITS  = COORD_BITS + wpc_pkg::LIMIT_LOG;
  localparam int DIV_BITS  = SUM_BITS + FRAC_BITS;
  localparam int CMP_BITS  = (REG_BITS > COORD_BITS) ? REG_BITS : COORD_BITS;

  logic [REG_BITS-1:0] win_left, win_right, win_top, win_bottom, excl_x, excl_y;

  logic [SUM_BITS-1:0] sum_x, sum_y, sum_x_next, sum_y_next;
  logic [CNT_BITS-1:0] hit_count, hit_count_next;

  logic [DIV_BITS-1:0] div_x, div_y;
  logic [CNT_BITS-1:0] rem_x, rem_y, div_cnt;

  logic [CMP_BITS-1:0] x_c, y_c;
  logic                hit;
  logic [CNT_BITS:0]   rem_sh_x, rem_sh_y, diff_x, diff_y, cnt_ext;
  logic                ge_x, ge_y;
  logic [CENT_BITS-1:0] cent_x_sat, cent_y_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= wpc_pkg::WIN_LEFT_RST;
      win_right  <= wpc_pkg::WIN_RIGHT_RST;
      win_top    <= wpc_pkg::WIN_TOP_RST;
      win_bottom <= wpc_pkg::WIN_BOTTOM_RST;
      excl_x     <= wpc_pkg::EXCL_X_RST;
      excl_y     <= wpc_pkg::EXCL_Y_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        wpc_pkg::REG_WIN_LEFT:   win_left   <= cfg.data;
        wpc_pkg::REG_WIN_RIGHT:  win_right  <= cfg.data;
        wpc_pkg::REG_WIN_TOP:    win_top    <= cfg.data;
        wpc_pkg::REG_WIN_BOTTOM: win_bottom <= cfg.data;
        wpc_pkg::REG_EXCL_X:     excl_x     <= cfg.data;
        wpc_pkg::REG_EXCL_Y:     excl_y     <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    x_c = CMP_BITS'(pos_x);
    y_c = CMP_BITS'(pos_y);
    hit = (pixel_value != '0)
          && (x_c >= CMP_BITS'(win_left)) && (x_c <= CMP_BITS'(win_right))
          && (y_c >= CMP_BITS'(win_top))  && (y_c <= CMP_BITS'(win_bottom))
          && ((x_c > CMP_BITS'(excl_x)) || (y_c < CMP_BITS'(excl_y)))
          && (hit_count < wpc_pkg::COUNT_LIMIT);
    sum_x_next     = hit ? sum_x + SUM_BITS'(pos_x) : sum_x;
    sum_y_next     = hit ? sum_y + SUM_BITS'(pos_y) : sum_y;
    hit_count_next = hit ? hit_count + CNT_BITS'(1) : hit_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x     <= '0;
      sum_y     <= '0;
      hit_count <= '0;
    end else if (cmd.load) begin
      sum_x     <= '0;
      sum_y     <= '0;
      hit_count <= '0;
    end else if (cmd.accum) begin
      sum_x     <= sum_x_next;
      sum_y     <= sum_y_next;
      hit_count <= hit_count_next;
    end
  end

  // restoring division, one quotient bit per cycle, both axes in step
  always_comb begin
    cnt_ext  = {1'b0, div_cnt};
    rem_sh_x = {rem_x, div_x[DIV_BITS-1]};
    rem_sh_y = {rem_y, div_y[DIV_BITS-1]};
    ge_x     = rem_sh_x >= cnt_ext;
    ge_y     = rem_sh_y >= cnt_ext;
    diff_x   = rem_sh_x - cnt_ext;
    diff_y   = rem_sh_y - cnt_ext;
    cent_x_sat = (|div_x[DIV_BITS-1:CENT_BITS]) ? '1 : div_x[CENT_BITS-1:0];
    cent_y_sat = (|div_y[DIV_BITS-1:CENT_BITS]) ? '1 : div_y[CENT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_x   <= DIV_BITS'(sum_x_next) << FRAC_BITS;
      div_y   <= DIV_BITS'(sum_y_next) << FRAC_BITS;
      rem_x   <= '0;
      rem_y   <= '0;
      div_cnt <= hit_count_next;
    end else if (cmd.step) begin
      div_x <= {div_x[DIV_BITS-2:0], ge_x};
      div_y <= {div_y[DIV_BITS-2:0], ge_y};
      rem_x <= ge_x ? diff_x[CNT_BITS-1:0] : rem_sh_x[CNT_BITS-1:0];
      rem_y <= ge_y ? diff_y[CNT_BITS-1:0] : rem_sh_y[CNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found       <= div_cnt != '0;
      pixel_total <= div_cnt;
      centroid_x  <= (div_cnt != '0) ? cent_x_sat : '0;
      centroid_y  <= (div_cnt != '0) ? cent_y_sat : '0;
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    hit_count <= wpc_pkg::COUNT_LIMIT)
    else $error("hit count past limit");

  a_clear_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (hit_count == '0) && (sum_x == '0) && (sum_y == '0))
    else $error("accumulators not cleared at frame end");

  a_found_total: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> found == (pixel_total != '0))
    else $error("found flag disagrees with total");

endmodule

/* sv/window_pixel_centroid_core.sv */
// Centroid of set pixels inside a configurable window.
// pix: one pixel per item (value, x, y, frame_last); taken one per cycle while
//   a frame streams in.
// res: one item per frame: found flag, centroid x/y with FRAC_BITS fraction
//   bits (truncated, saturated to 16 bits), and pixel count.
// cfg: register writes (index, data), always ready; write only while idle.
// Sequence: after the frame_last pixel is taken, the divider produces one
//   quotient bit per cycle for x and y together, then the result register
//   is loaded once any item still held in it has been taken.
// Throughput: one pixel per cycle inside a frame; pix.ready is low for the
//   divide and finish cycles after each frame_last pixel.
// Receiver stall: the result register holds its item; the next frame streams
//   in meanwhile, and its end waits until the held item is taken.
// Reset: window registers return to defaults, accumulators clear, res.valid
//   drops.
module window_pixel_centroid_core #(
  parameter int COORD_BITS = wpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = wpc_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wpc_pixel_if.sink  pix,
  wpc_result_if.source res,
  wpc_cfg_if.sink    cfg
);

  localparam int DIV_STEPS = COORD_BITS + wpc_pkg::LIMIT_LOG + FRAC_BITS;

  wpc_pkg::wpc_cmd_t cmd;

  wpc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_last   (pix.frame_last),
    .in_ready  (pix.ready),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .cmd       (cmd)
  );

  wpc_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .pixel_value (pix.pixel_value),
    .pos_x       (pix.pos_x),
    .pos_y       (pix.pos_y),
    .cfg         (cfg),
    .found       (res.found),
    .centroid_x  (res.centroid_x),
    .centroid_y  (res.centroid_y),
    .pixel_total (res.pixel_total)
  );

endmodule

/* tb/window_pixel_centroid_core_test.sv */
module window_pixel_centroid_core_test;
  import wpc_pkg::*;

  localparam int COORD = COORD_BITS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int SETTLE = COORD + FRAC + 26 + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 36;

  localparam logic [IDX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic found;
    logic [CENT_BITS-1:0] centroid_x;
    logic [CENT_BITS-1:0] centroid_y;
    logic [CNT_BITS-1:0] pixel_total;
  } centroid_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COORD-1:0] x;
    logic [COORD-1:0] y;
    logic last;
    logic pinned;
    centroid_t want;
  } pixel_row_t;

  localparam int SCRIPT_LEN = 17;
  localparam pixel_row_t SCRIPT [SCRIPT_LEN] = '{
    '{8'd0,   12'd0,     12'd0,     1'b1, 1'b1, '{1'b0, 16'd0,     16'd0,     25'd0}},
    '{8'd255, 12'd4095,  12'd4095,  1'b0, 1'b0, '0},
    '{8'd1,   12'd4095,  12'd0,     1'b1, 1'b1, '{1'b1, 16'd65520, 16'd32760, 25'd2}},
    '{8'd255, 12'd350,   12'd1550,  1'b1, 1'b1, '{1'b0, 16'd0,     16'd0,     25'd0}},
    '{8'd1,   12'd350,   12'd1549,  1'b1, 1'b1, '{1'b1, 16'd5600,  16'd24784, 25'd1}},
    '{8'd128, 12'd351,   12'd4095,  1'b1, 1'b1, '{1'b1, 16'd5616,  16'd65520, 25'd1}},
    '{8'd0,   12'd2000,  12'd100,   1'b0, 1'b0, '0},
    '{8'd255, 12'd0,     12'd0,     1'b1, 1'b1, '{1'b1, 16'd0,     16'd0,     25'd1}},
    '{8'd1,   12'd1,     12'd0,     1'b0, 1'b0, '0},
    '{8'd2,   12'd0,     12'd0,     1'b0, 1'b0, '0},
    '{8'd3,   12'd0,     12'd0,     1'b1, 1'b1, '{1'b1, 16'd5,     16'd0,     25'd3}},
    '{8'h55,  12'hAAA,   12'h555,   1'b0, 1'b0, '0},
    '{8'hAA,  12'h555,   12'hAAA,   1'b0, 1'b0, '0},
    '{8'h80,  12'h800,   12'h7FF,   1'b1, 1'b0, '0},
    '{8'd255, 12'd351,   12'd1549,  1'b0, 1'b0, '0},
    '{8'd255, 12'd349,   12'd1551,  1'b0, 1'b0, '0},
    '{8'd7,   12'd4000,  12'd3000,  1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  logic pin_on = 1'b0;
  centroid_t pin_want = '0;

  wpc_pixel_if pix ();
  wpc_result_if res ();
  wpc_cfg_if cfg ();

  window_pixel_centroid_core dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  always #10 clk = ~clk;

  logic [REG_BITS-1:0] lo_x = WIN_LEFT_RST;
  logic [REG_BITS-1:0] hi_x = WIN_RIGHT_RST;
  logic [REG_BITS-1:0] lo_y = WIN_TOP_RST;
  logic [REG_BITS-1:0] hi_y = WIN_BOTTOM_RST;
  logic [REG_BITS-1:0] skip_x = EXCL_X_RST;
  logic [REG_BITS-1:0] skip_y = EXCL_Y_RST;
  logic [35:0] x_sum = '0;
  logic [35:0] y_sum = '0;
  logic [CNT_BITS-1:0] hits = '0;

  centroid_t centroid_q [$];
  int errors = 0;
  int pixels_in = 0;
  int frames_out = 0;
  int settings = 0;
  int cycles = 0;

  function automatic logic [CENT_BITS-1:0] mean_q4(input logic [35:0] sum,
                                                   input logic [CNT_BITS-1:0] n);
    logic [63:0] q;
    if (n == 0) return '0;
    q = (64'(sum) << FRAC) / 64'(n);
    return (q > 64'hFFFF) ? 16'hFFFF : q[CENT_BITS-1:0];
  endfunction

  function automatic void accumulate(input logic [VALUE_BITS-1:0] value,
                                     input logic [COORD-1:0] x, y,
                                     input logic last,
                                     output centroid_t frame);
    logic in_win, passes;
    in_win = x >= lo_x && x <= hi_x && y >= lo_y && y <= hi_y;
    passes = x > skip_x || y < skip_y;
    if (value != 0 && in_win && passes && hits < COUNT_LIMIT) begin
      x_sum += 36'(x);
      y_sum += 36'(y);
      hits += CNT_BITS'(1);
    end
    frame = '0;
    if (last) begin
      frame.found = hits != 0;
      frame.centroid_x = mean_q4(x_sum, hits);
      frame.centroid_y = mean_q4(y_sum, hits);
      frame.pixel_total = hits;
      x_sum = '0;
      y_sum = '0;
      hits = '0;
    end
  endfunction

  function automatic void store_reg(input logic [IDX_BITS-1:0] idx,
                                    input logic [REG_BITS-1:0] data);
    case (idx)
      REG_WIN_LEFT: lo_x = data;
      REG_WIN_RIGHT: hi_x = data;
      REG_WIN_TOP: lo_y = data;
      REG_WIN_BOTTOM: hi_y = data;
      REG_EXCL_X: skip_x = data;
      REG_EXCL_Y: skip_y = data;
      default: ;
    endcase
  endfunction

  function automatic logic [COORD-1:0] pick_coord(input logic [COORD-1:0] lo, hi);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 70 && lo <= hi) return COORD'($urandom_range(hi, lo));
    return COORD'($urandom_range(4095, 0));
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 35) return '1;
    return VALUE_BITS'($urandom_range(255, 1));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, centroid_q.size());
      $display("[window_pixel_centroid_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    res.ready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin : watch
    centroid_t calc, got, want;
    if (!rst) begin
      if (cfg.valid && cfg.ready) store_reg(cfg.index, cfg.data);
      if (pix.valid && pix.ready) begin
        pixels_in++;
        accumulate(pix.pixel_value, pix.pos_x, pix.pos_y, pix.frame_last, calc);
        if (pix.frame_last) centroid_q.push_back(pin_on ? pin_want : calc);
      end
      if (res.valid && res.ready) begin
        got = '{res.found, res.centroid_x, res.centroid_y, res.pixel_total};
        frames_out++;
        if (centroid_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: found %0d x %0d y %0d total %0d",
                   $time, got.found, got.centroid_x, got.centroid_y, got.pixel_total);
        end else begin
          want = centroid_q.pop_front();
          if (got.found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
          end
          if (got.centroid_x !== want.centroid_x) begin
            errors++;
            $display("%0t: centroid_x expected %0d, got %0d", $time,
                     want.centroid_x, got.centroid_x);
          end
          if (got.centroid_y !== want.centroid_y) begin
            errors++;
            $display("%0t: centroid_y expected %0d, got %0d", $time,
                     want.centroid_y, got.centroid_y);
          end
          if (got.pixel_total !== want.pixel_total) begin
            errors++;
            $display("%0t: pixel_total expected %0d, got %0d", $time,
                     want.pixel_total, got.pixel_total);
          end
        end
      end
    end
  end

  task automatic send_pixel(input logic [VALUE_BITS-1:0] value,
                            input logic [COORD-1:0] x, y,
                            input logic last, pinned,
                            input centroid_t want);
    while (!calm && $urandom_range(99) < 23) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_value <= value;
    pix.pos_x <= x;
    pix.pos_y <= y;
    pix.frame_last <= last;
    pin_on <= pinned;
    pin_want <= want;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  // hold the stream until every frame result has come back
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (centroid_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic set_window(input logic [REG_BITS-1:0] l, r, t, b, ex, ey);
    write_reg(REG_WIN_LEFT, l);
    write_reg(REG_WIN_RIGHT, r);
    write_reg(REG_WIN_TOP, t);
    write_reg(REG_WIN_BOTTOM, b);
    write_reg(REG_EXCL_X, ex);
    write_reg(REG_EXCL_Y, ey);
    write_reg(REG_SPARE_A, REG_BITS'($urandom_range(4095, 0)));
    write_reg(REG_SPARE_B, REG_BITS'($urandom_range(4095, 0)));
    cfg.valid <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [REG_BITS-1:0] a, b, c, d;
    int sent, len;
    pix.valid = 1'b0;
    pix.pixel_value = '0;
    pix.pos_x = '0;
    pix.pos_y = '0;
    pix.frame_last = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_WIN_LEFT;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (SCRIPT[i])
      send_pixel(SCRIPT[i].value, SCRIPT[i].x, SCRIPT[i].y, SCRIPT[i].last,
                 SCRIPT[i].pinned, SCRIPT[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      repeat (SETTLE) @(posedge clk);
      case (p)
        0: set_window(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd350, 12'd1550);
        1: set_window(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0);
        2: set_window(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095);
        3: set_window(12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4094, 12'd0);
        default: begin
          a = REG_BITS'($urandom_range(4095, 0));
          b = REG_BITS'($urandom_range(4095, 0));
          c = REG_BITS'($urandom_range(4095, 0));
          d = REG_BITS'($urandom_range(4095, 0));
          if ($urandom_range(9) < 8) begin
            if (a > b) {a, b} = {b, a};
            if (c > d) {c, d} = {d, c};
          end
          set_window(a, b, c, d, REG_BITS'($urandom_range(4095, 0)),
                     REG_BITS'($urandom_range(4095, 0)));
        end
      endcase
      calm = (p == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(12, 1);
        for (int k = 0; k < len; k++)
          send_pixel(pick_value(), pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y),
                     k == len - 1, 1'b0, '0);
        sent += len;
        if ($urandom_range(9) == 0) drain();
      end
      calm = 1'b0;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("%0d pixel items in, %0d frame results checked, %0d window settings",
             pixels_in, frames_out, settings);
    $display("covered empty and single-pixel windows, exclusion extremes and idle gaps");
    if (errors == 0) begin
      $display("[window_pixel_centroid_core] OK");
    end else begin
      $display("[window_pixel_centroid_core] ERROR");
    end
    $finish;
  end

endmodule
